// ===== hw/rtl/plst_pkg.sv =====
// shared types and constants for the positional list store
// item field widths, command and status codes, sequencer states
// no dependencies
`default_nettype none

package plst_pkg;

   // item field widths
   localparam int ACT_W      = 3;
   localparam int POS_W      = 6;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 7;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;

   // command codes
   typedef enum logic [ACT_W-1:0] {
      ACT_INSERT   = 3'd0,
      ACT_DELETE   = 3'd1,
      ACT_APPEND   = 3'd2,
      ACT_POP      = 3'd3,
      ACT_POP_LAST = 3'd4,
      ACT_READ     = 3'd5,
      ACT_RESTART  = 3'd6
   } action_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STS_OK      = 2'd0,
      STS_BAD_POS = 2'd1,
      STS_SOLE    = 2'd2,
      STS_FULL    = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_WALK   = 2'd1,
      S_FINISH = 2'd2
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/positional_list_store_unit.sv =====
// Positional list store: an ordered list of up to CAPACITY signed 32-bit values held in
// one synchronous memory, never empty, one zero entry after reset. A command is taken and
// its result leaves through an output register, so the next command is accepted while a
// result still waits. Commands that move entries walk the memory one entry per cycle
// through its single read and write port: insert shifts entries from the position up,
// delete and pop at a position shift entries above it down, read and pop last read one
// entry; append, restart and rejected commands do not walk. No clearing pass is needed.
// depends on plst_pkg and plst_store
`default_nettype none

module positional_list_store_unit #(
   parameter int CAPACITY = 64
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // action [2:0], position [8:3], item_value [40:9], zero pad [47:41]
   input  wire logic [plst_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // out_value [31:0], status [33:32], entry_count [40:34], zero pad [47:41]
   output logic      [plst_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int AW   = $clog2(CAPACITY);
   localparam int CMPW = (CW > plst_pkg::POS_W) ? CW : plst_pkg::POS_W;

   // item fields
   plst_pkg::action_type              act;
   logic [plst_pkg::POS_W-1:0]        pos;
   logic [plst_pkg::VALUE_W-1:0]      val;
   logic                              req_fire;
   logic                              out_free;

   // accept-time decode
   logic [CMPW-1:0]                   pos_ext;
   logic [CMPW-1:0]                   cnt_ext;
   logic [CMPW-1:0]                   cnt_m1;
   logic [CMPW-1:0]                   cap_ext;
   logic [CMPW-1:0]                   ipos;
   plst_pkg::status_type              dec_status;
   logic                              dec_walk;
   logic                              dec_down;
   logic [CMPW-1:0]                   dec_start;
   logic [CMPW-1:0]                   dec_end;
   logic                              dec_capture;
   logic                              dec_final;
   logic [CMPW-1:0]                   dec_final_addr;
   logic [CMPW-1:0]                   dec_count;

   // sequencer and command registers
   plst_pkg::state_type               state_ff, state_in;
   logic [CW-1:0]                     count_ff, count_in;
   plst_pkg::status_type              status_ff, status_in;
   logic                              capture_ff, capture_in;
   logic                              final_ff, final_in;
   logic [AW-1:0]                     final_addr_ff, final_addr_in;
   logic [plst_pkg::VALUE_W-1:0]      val_ff, val_in;
   logic                              down_ff, down_in;
   logic [AW-1:0]                     start_ff, start_in;
   logic [AW-1:0]                     end_ff, end_in;
   logic [AW-1:0]                     ptr_ff, ptr_in;
   logic                              more_ff, more_in;
   logic                              pend_ff, pend_in;
   logic [AW-1:0]                     src_ff, src_in;
   logic [plst_pkg::VALUE_W-1:0]      cap_ff, cap_in;

   // output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [plst_pkg::VALUE_W-1:0]      rsp_value_ff, rsp_value_in;
   plst_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic [plst_pkg::COUNT_W-1:0]      rsp_count_ff, rsp_count_in;

   // memory port
   logic                              wr_en;
   logic [AW-1:0]                     wr_addr;
   logic [plst_pkg::VALUE_W-1:0]      wr_data;
   logic                              rd_en;
   logic [plst_pkg::VALUE_W-1:0]      rd_data;

   // field unpacking and handshakes
   assign act      = plst_pkg::action_type'(req_tdata[2:0]);
   assign pos      = req_tdata[8:3];
   assign val      = req_tdata[40:9];
   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign pos_ext = CMPW'(pos);
   assign cnt_ext = CMPW'(count_ff);
   assign cnt_m1  = cnt_ext - CMPW'(1);
   assign cap_ext = CMPW'(CAPACITY);

   // command decode against the current count
   always_comb begin
      dec_status     = plst_pkg::STS_OK;
      dec_walk       = 1'b0;
      dec_down       = 1'b0;
      dec_start      = pos_ext;
      dec_end        = pos_ext;
      dec_capture    = 1'b0;
      dec_final      = 1'b0;
      dec_final_addr = '0;
      dec_count      = cnt_ext;
      ipos           = (act == plst_pkg::ACT_APPEND) ? cnt_ext : pos_ext;
      case (act)
         plst_pkg::ACT_INSERT, plst_pkg::ACT_APPEND: begin
            if ((act == plst_pkg::ACT_INSERT) && (pos_ext > cnt_ext)) begin
               dec_status = plst_pkg::STS_BAD_POS;
            end else if (cnt_ext >= cap_ext) begin
               dec_status = plst_pkg::STS_FULL;
            end else begin
               dec_final      = 1'b1;
               dec_final_addr = ipos;
               dec_count      = cnt_ext + CMPW'(1);
               if (ipos < cnt_ext) begin
                  dec_walk  = 1'b1;
                  dec_down  = 1'b1;
                  dec_start = cnt_m1;
                  dec_end   = ipos;
               end
            end
         end
         plst_pkg::ACT_DELETE, plst_pkg::ACT_POP, plst_pkg::ACT_READ: begin
            if (pos_ext >= cnt_ext) begin
               dec_status = plst_pkg::STS_BAD_POS;
            end else begin
               dec_walk    = 1'b1;
               dec_start   = pos_ext;
               dec_end     = (act == plst_pkg::ACT_READ) ? pos_ext : cnt_m1;
               dec_capture = (act != plst_pkg::ACT_DELETE);
               if ((act != plst_pkg::ACT_READ) && (cnt_ext > CMPW'(1))) begin
                  dec_count = cnt_m1;
               end
            end
         end
         plst_pkg::ACT_POP_LAST: begin
            if (cnt_ext <= CMPW'(1)) begin
               dec_status = plst_pkg::STS_SOLE;
            end else begin
               dec_walk    = 1'b1;
               dec_start   = cnt_m1;
               dec_end     = cnt_m1;
               dec_capture = 1'b1;
               dec_count   = cnt_m1;
            end
         end
         plst_pkg::ACT_RESTART: begin
            dec_final      = 1'b1;
            dec_final_addr = '0;
            dec_count      = CMPW'(1);
         end
         default: begin
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         plst_pkg::S_IDLE: begin
            if (req_fire) begin
               state_in = dec_walk ? plst_pkg::S_WALK : plst_pkg::S_FINISH;
            end
         end
         plst_pkg::S_WALK: begin
            if (!more_ff && !pend_ff) begin
               state_in = plst_pkg::S_FINISH;
            end
         end
         plst_pkg::S_FINISH: begin
            if (out_free) begin
               state_in = plst_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = plst_pkg::S_IDLE;
         end
      endcase
   end

   // sequencer outputs: handshake and memory port
   always_comb begin
      req_tready = 1'b0;
      rd_en      = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = src_ff;
      wr_data    = rd_data;
      case (state_ff)
         plst_pkg::S_IDLE: begin
            req_tready = 1'b1;
         end
         plst_pkg::S_WALK: begin
            rd_en = more_ff;
            if (pend_ff) begin
               if (down_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = src_ff + AW'(1);
               end else begin
                  wr_en   = (src_ff != start_ff);
                  wr_addr = src_ff - AW'(1);
               end
            end
         end
         plst_pkg::S_FINISH: begin
            wr_en   = final_ff && out_free;
            wr_addr = final_addr_ff;
            wr_data = val_ff;
         end
         default: begin
         end
      endcase
   end

   // command registers and shift walk
   always_comb begin
      count_in      = count_ff;
      status_in     = status_ff;
      capture_in    = capture_ff;
      final_in      = final_ff;
      final_addr_in = final_addr_ff;
      val_in        = val_ff;
      down_in       = down_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      ptr_in        = ptr_ff;
      more_in       = more_ff;
      pend_in       = 1'b0;
      src_in        = ptr_ff;
      cap_in        = cap_ff;
      if (req_fire) begin
         count_in      = dec_count[CW-1:0];
         status_in     = dec_status;
         capture_in    = dec_capture;
         final_in      = dec_final;
         final_addr_in = dec_final_addr[AW-1:0];
         val_in        = val;
         down_in       = dec_down;
         start_in      = dec_start[AW-1:0];
         end_in        = dec_end[AW-1:0];
         ptr_in        = dec_start[AW-1:0];
         more_in       = dec_walk;
         cap_in        = '0;
      end
      if (state_ff == plst_pkg::S_WALK) begin
         // issue the next read of the walk
         pend_in = more_ff;
         if (more_ff) begin
            if (ptr_ff == end_ff) begin
               more_in = 1'b0;
            end else begin
               ptr_in = down_ff ? (ptr_ff - AW'(1)) : (ptr_ff + AW'(1));
            end
         end
         // keep the value found at the command's own position
         if (pend_ff && !down_ff && capture_ff && (src_ff == start_ff)) begin
            cap_in = rd_data;
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      if ((state_ff == plst_pkg::S_FINISH) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = cap_ff;
         rsp_status_in = status_ff;
         rsp_count_in  = plst_pkg::COUNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plst_pkg::S_IDLE;
         count_ff     <= CW'(1);
         more_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         more_ff      <= more_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      capture_ff    <= capture_in;
      final_ff      <= final_in;
      final_addr_ff <= final_addr_in;
      val_ff        <= val_in;
      down_ff       <= down_in;
      start_ff      <= start_in;
      end_ff        <= end_in;
      ptr_ff        <= ptr_in;
      src_ff        <= src_in;
      cap_ff        <= cap_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // entry memory
   plst_store #(
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   // result packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {
      {(plst_pkg::RSP_DATA_W - plst_pkg::VALUE_W - plst_pkg::STATUS_W
        - plst_pkg::COUNT_W){1'b0}},
      rsp_count_ff, rsp_status_ff, rsp_value_ff
   };

   // the list never becomes empty nor grows past capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) && (CMPW'(count_ff) <= cap_ext))
      else $error("entry count out of range");

   // read data is only pending while the walk is running
   a_pend_in_walk: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == plst_pkg::S_WALK))
      else $error("memory read outstanding outside the walk");

   // an accepted command leaves idle on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != plst_pkg::S_IDLE))
      else $error("sequencer stayed idle after accepting an item");

endmodule

`default_nettype wire

// ===== hw/rtl/plst_store.sv =====
// entry memory of the positional list store: one write and one read port,
// registered read data; entry zero reads as zero until first written
// uses plst_pkg for the value width
`default_nettype none

module plst_store #(
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          wr_en,
   input  wire logic [AW-1:0]                 wr_addr,
   input  wire logic [plst_pkg::VALUE_W-1:0]  wr_data,
   input  wire logic                          rd_en,
   input  wire logic [AW-1:0]                 rd_addr,
   output logic      [plst_pkg::VALUE_W-1:0]  rd_data
);

   logic [plst_pkg::VALUE_W-1:0] mem [DEPTH];
   logic [plst_pkg::VALUE_W-1:0] q_ff;
   logic                         zero_written_ff;
   logic                         zero_written_in;
   logic                         rd_zero_ff;
   logic                         rd_zero_in;

   // memory array, synchronous read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff <= mem[rd_addr];
      end
   end

   // entry zero holds its reset value until written
   always_comb begin
      zero_written_in = zero_written_ff | (wr_en && (wr_addr == '0));
      rd_zero_in      = rd_en ? ((rd_addr == '0) && !zero_written_ff) : rd_zero_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_written_ff <= 1'b0;
         rd_zero_ff      <= 1'b0;
      end else begin
         zero_written_ff <= zero_written_in;
         rd_zero_ff      <= rd_zero_in;
      end
   end

   assign rd_data = rd_zero_ff ? '0 : q_ff;

   // the shift walk never reads and writes one entry in the same cycle
   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en && (wr_addr == rd_addr)))
      else $error("read and write of the same entry in one cycle");

endmodule

`default_nettype wire
